// ===== design/u8dec_pkg.sv =====
// Types, codes and decode helpers for the UTF-8 to UCS-2 stream decoder.
// Self-contained; used by utf8_to_ucs2_stream_decoder.
`timescale 1ns / 1ps

package u8dec_pkg;

  // buffer length limit; both counts saturate at the lesser of this and 0xFFFF
  localparam int unsigned MAX_BUFFER_LEN = 32'd65535;
  localparam logic [15:0] CNT_CAP = (MAX_BUFFER_LEN < 32'h0000_FFFF) ?
                                    MAX_BUFFER_LEN[15:0] : 16'hFFFF;

  localparam logic [15:0] REPL_CP = 16'hFFFD;
  localparam logic [15:0] MIN_CP2 = 16'h0080;
  localparam logic [15:0] MIN_CP3 = 16'h0800;

  // output word layout
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    MODE_STRICT   = 2'd0,
    MODE_SKIP     = 2'd1,
    MODE_REPLACE  = 2'd2,
    MODE_CONFLICT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CHAR     = 3'd0,
    ST_DONE     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_OVERLONG = 3'd3,
    ST_CONFLICT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ACT_BREAK = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_SKIP  = 2'd2,
    ACT_ERROR = 2'd3
  } act_t;

  typedef logic [2:0][7:0] win_t;

  typedef struct packed {
    act_t        act;
    logic [15:0] cp;
    logic [1:0]  used;
    status_t     st;
  } decision_t;

  // saturating add of a small byte or char increment
  function automatic logic [15:0] sat_add(logic [15:0] v, logic [1:0] n, logic [15:0] cap);
    logic [16:0] s;
    s = {1'b0, v} + {15'b0, n};
    return (s > {1'b0, cap}) ? cap : s[15:0];
  endfunction

  // one decision on the head of the window
  function automatic decision_t decide(win_t w, logic [1:0] f, logic fin, mode_t mode);
    decision_t   d;
    logic [15:0] cp2;
    logic [15:0] cp3;
    logic        lead2;
    logic        lead3;
    cp2   = {5'b0, w[0][4:0], w[1][5:0]};
    cp3   = {w[0][3:0], w[1][5:0], w[2][5:0]};
    lead2 = (w[0][7:5] == 3'b110) && (w[1][7:6] == 2'b10);
    lead3 = (w[0][7:4] == 4'b1110) && (w[1][7:6] == 2'b10) && (w[2][7:6] == 2'b10);
    d.act  = ACT_BREAK;
    d.cp   = 16'h0000;
    d.used = 2'd0;
    d.st   = ST_CHAR;
    if (!w[0][7]) begin
      d.act  = ACT_CHAR;
      d.cp   = {8'h00, w[0]};
      d.used = 2'd1;
    end else if (f < 2'd2 || (!lead2 && f < 2'd3)) begin
      // incomplete head: wait for more bytes unless the buffer ends here
      if (!fin) begin
        d.act = ACT_BREAK;
      end else if (mode == MODE_REPLACE) begin
        d.act  = ACT_CHAR;
        d.cp   = REPL_CP;
        d.used = 2'd1;
      end else begin
        d.act = ACT_ERROR;
        d.st  = ST_INVALID;
      end
    end else if (lead2) begin
      if (cp2 < MIN_CP2) begin
        d.act = ACT_ERROR;
        d.st  = ST_OVERLONG;
      end else begin
        d.act  = ACT_CHAR;
        d.cp   = cp2;
        d.used = 2'd2;
      end
    end else if (lead3) begin
      if (cp3 < MIN_CP3) begin
        d.act = ACT_ERROR;
        d.st  = ST_OVERLONG;
      end else begin
        d.act  = ACT_CHAR;
        d.cp   = cp3;
        d.used = 2'd3;
      end
    end else if (mode == MODE_SKIP) begin
      d.act = ACT_SKIP;
    end else if (mode == MODE_REPLACE) begin
      d.act  = ACT_CHAR;
      d.cp   = REPL_CP;
      d.used = 2'd1;
    end else begin
      d.act = ACT_ERROR;
      d.st  = ST_INVALID;
    end
    return d;
  endfunction

endpackage

// ===== design/utf8_to_ucs2_stream_decoder.sv =====
// Top level of the UTF-8 to UCS-2 stream decoder: byte window, decode step,
// counters and output register. Depends on u8dec_pkg.
`timescale 1ns / 1ps
// The first result of a byte sits in the output register in the cycle after it is taken.
// Throughput: one byte per cycle while no decode step is pending and the output is not stalled;
// each further decode step (one result, up to 4 per byte with the end-of-buffer word, one skipped
// byte, or a last check of leftover bytes that still wait for their sequence) holds the input.
// Reset (rst, synchronous) clears the window, counts, stop flag and output valid, and sets
// mode to strict.

module utf8_to_ucs2_stream_decoder #(
  parameter int unsigned MAX_BUFFER_LEN = u8dec_pkg::MAX_BUFFER_LEN
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,      // mode
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tlast,  // last_byte
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [u8dec_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [15:0] ucs2_char, [31:16] decoded_count, [47:32] consumed_bytes
  output logic [2:0]  m_axis_tuser,  // [2:0] status
  output logic        m_axis_tlast   // last_of_run
);

  // count limit: the lesser of the buffer length and 0xFFFF
  localparam logic [15:0] CNT_CAP = (MAX_BUFFER_LEN < 32'h0000_FFFF) ?
                                    16'(MAX_BUFFER_LEN) : 16'hFFFF;

  u8dec_pkg::mode_t     mode;
  u8dec_pkg::win_t      win, win_next, wv, sw;
  logic [1:0]           fill, fill_next, fv, sf;
  logic [15:0]          char_count, char_count_next;
  logic [15:0]          byte_position, byte_position_next;
  logic                 stopped, stopped_next;
  logic                 busy, busy_next;
  logic                 fin_r, fin_next, finv;
  logic                 accept, slot_free, do_clear;
  logic [2:0]           idx;
  logic [1:0]           drop_n;
  u8dec_pkg::decision_t dec;

  // staged result
  logic                 emit;
  logic [15:0]          e_cp, e_cnt, e_pos;
  u8dec_pkg::status_t   e_st;
  logic                 e_last;

  // output register
  logic                 out_valid;
  logic [15:0]          out_cp, out_cnt, out_pos;
  u8dec_pkg::status_t   out_st;
  logic                 out_last;

  assign slot_free     = !out_valid || m_axis_tready;
  assign s_axis_tready = !busy && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // window view: registered window, with the incoming byte appended on accept
  always_comb begin
    wv   = win;
    fv   = fill;
    finv = fin_r;
    if (accept) begin
      case (fill)
        2'd0:    wv[0] = s_axis_tdata;
        2'd1:    wv[1] = s_axis_tdata;
        default: wv[2] = s_axis_tdata;
      endcase
      fv   = (fill == 2'd3) ? fill : fill + 2'd1;
      finv = s_axis_tlast;
    end
  end

  assign dec    = u8dec_pkg::decide(wv, fv, finv, mode);
  assign drop_n = (dec.act == u8dec_pkg::ACT_SKIP) ? 2'd1 : dec.used;

  // window after dropping the consumed bytes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      idx   = 3'(i) + {1'b0, drop_n};
      sw[i] = (idx < {1'b0, fv}) ? wv[idx[1:0]] : 8'h00;
    end
    sf = fv - drop_n;
  end

  // one decode step per cycle while the output slot is free
  always_comb begin
    win_next           = win;
    fill_next          = fill;
    char_count_next    = char_count;
    byte_position_next = byte_position;
    stopped_next       = stopped;
    busy_next          = busy;
    fin_next           = fin_r;
    do_clear           = 1'b0;
    emit               = 1'b0;
    e_cp               = 16'h0000;
    e_st               = u8dec_pkg::ST_CHAR;
    e_cnt              = char_count;
    e_pos              = byte_position;
    e_last             = 1'b0;
    if (accept && stopped) begin
      // dropped byte; the final one only clears
      do_clear = finv;
    end else if (accept && mode == u8dec_pkg::MODE_CONFLICT) begin
      emit         = 1'b1;
      e_st         = u8dec_pkg::ST_CONFLICT;
      e_last       = 1'b1;
      stopped_next = 1'b1;
      do_clear     = finv;
    end else if (accept || (busy && slot_free)) begin
      fin_next = finv;
      if (fv == 2'd0) begin
        // window drained at the end of the buffer
        emit     = 1'b1;
        e_st     = u8dec_pkg::ST_DONE;
        e_last   = 1'b1;
        do_clear = 1'b1;
      end else begin
        case (dec.act)
          u8dec_pkg::ACT_CHAR: begin
            win_next           = sw;
            fill_next          = sf;
            char_count_next    = u8dec_pkg::sat_add(char_count, 2'd1, CNT_CAP);
            byte_position_next = u8dec_pkg::sat_add(byte_position, dec.used, CNT_CAP);
            emit               = 1'b1;
            e_cp               = dec.cp;
            e_cnt              = char_count_next;
            e_pos              = byte_position_next;
            busy_next          = finv || (sf != 2'd0);
          end
          u8dec_pkg::ACT_SKIP: begin
            win_next           = sw;
            fill_next          = sf;
            byte_position_next = u8dec_pkg::sat_add(byte_position, 2'd1, CNT_CAP);
            busy_next          = finv || (sf != 2'd0);
          end
          u8dec_pkg::ACT_ERROR: begin
            win_next     = wv;
            fill_next    = fv;
            emit         = 1'b1;
            e_st         = dec.st;
            e_last       = 1'b1;
            stopped_next = 1'b1;
            busy_next    = 1'b0;
            do_clear     = finv;
          end
          default: begin
            win_next  = wv;
            fill_next = fv;
            busy_next = 1'b0;
          end
        endcase
      end
    end
    if (do_clear) begin
      win_next           = '0;
      fill_next          = 2'd0;
      char_count_next    = 16'h0000;
      byte_position_next = 16'h0000;
      stopped_next       = 1'b0;
      busy_next          = 1'b0;
      fin_next           = 1'b0;
    end
  end

  // decoder state and mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= u8dec_pkg::MODE_STRICT;
      win           <= '0;
      fill          <= 2'd0;
      char_count    <= 16'h0000;
      byte_position <= 16'h0000;
      stopped       <= 1'b0;
      busy          <= 1'b0;
      fin_r         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= u8dec_pkg::mode_t'(cfg_data);
      end
      win           <= win_next;
      fill          <= fill_next;
      char_count    <= char_count_next;
      byte_position <= byte_position_next;
      stopped       <= stopped_next;
      busy          <= busy_next;
      fin_r         <= fin_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      out_cp   <= e_cp;
      out_st   <= e_st;
      out_cnt  <= e_cnt;
      out_pos  <= e_pos;
      out_last <= e_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_st;
  assign m_axis_tdata  = {out_pos, out_cnt, out_cp};

`ifndef NO_ASSERTIONS
  // a full window is always resolved before the next byte is taken, unless stopped
  a_fill_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (fill != 2'd3 || stopped))
    else $error("window full while idle");

  // a stopped buffer has no decode steps left
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !busy)
    else $error("decode step pending on a stopped buffer");

  // only non-character words close a buffer
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (out_st != u8dec_pkg::ST_CHAR)))
    else $error("last flag does not match status");

  // every character consumes at least one byte
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_cnt <= out_pos)
    else $error("character count exceeds consumed bytes");
`endif

endmodule

// ===== test/tb_utf8_to_ucs2_stream_decoder.sv =====
// Self-checking testbench for the UTF-8 to UCS-2 stream decoder: directed and random
// byte buffers in all four modes, checked word by word against a built-in predictor.
// Depends on u8dec_pkg and utf8_to_ucs2_stream_decoder.
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_stream_decoder;

  localparam int PHASES         = 12;
  localparam int PRESSURE_PHASE = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_LIMIT   = 20000;
  localparam int TAIL_CYCLES    = 8;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } utf8_item_t;

  typedef struct packed {
    logic [15:0]        cp;
    u8dec_pkg::status_t st;
    logic [15:0]        chars;
    logic [15:0]        consumed;
    logic               last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = 2'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;    // last_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [u8dec_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // [15:0] ucs2_char, [31:16] decoded_count, [47:32] consumed_bytes
  logic [2:0] m_axis_tuser;           // [2:0] status
  logic       m_axis_tlast;           // last_of_run

  utf8_item_t utf8_q[$];
  decoded_t   decoded_q[$];
  int         queued_items = 0;
  int         err_count = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  logic       hold_req = 1'b0;
  logic       rx_hold = 1'b0;

  // predictor state
  u8dec_pkg::mode_t model_mode = u8dec_pkg::MODE_STRICT;
  logic [7:0]  win_bytes[3] = '{default: 8'h00};
  int          win_fill = 0;
  logic [15:0] chars_out = '0;
  logic [15:0] bytes_done = '0;
  logic        halted = 1'b0;

  utf8_to_ucs2_stream_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic logic [15:0] count_add(input logic [15:0] v, input int n);
    logic [16:0] s;
    s = {1'b0, v} + 17'(n);
    return (s > {1'b0, u8dec_pkg::CNT_CAP}) ? u8dec_pkg::CNT_CAP : s[15:0];
  endfunction

  task automatic expect_word(input logic [15:0] cp, input u8dec_pkg::status_t st,
                             input logic last);
    decoded_q.push_back(decoded_t'{cp, st, chars_out, bytes_done, last});
  endtask

  // drop n bytes from the head of the window
  task automatic shift_window(input int n);
    if (n > win_fill) n = win_fill;
    for (int i = 0; i < 3; i++)
      win_bytes[i] = (i + n < win_fill) ? win_bytes[i + n] : 8'h00;
    win_fill   = win_fill - n;
    bytes_done = count_add(bytes_done, n);
  endtask

  task automatic clear_buffer();
    for (int i = 0; i < 3; i++) win_bytes[i] = 8'h00;
    win_fill   = 0;
    chars_out  = '0;
    bytes_done = '0;
    halted     = 1'b0;
  endtask

  // predict the words released by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [15:0]        cp;
    u8dec_pkg::status_t st;
    int                 used;
    logic               skip;
    logic               starve;
    logic               busy;
    if (!halted) begin
      if (model_mode == u8dec_pkg::MODE_CONFLICT) begin
        expect_word(16'h0000, u8dec_pkg::ST_CONFLICT, 1'b1);
        halted = 1'b1;
      end else begin
        if (win_fill < 3) begin
          win_bytes[win_fill] = b;
          win_fill++;
        end
        busy = 1'b1;
        while (busy && !halted && win_fill > 0) begin
          b0 = win_bytes[0];
          b1 = win_bytes[1];
          b2 = win_bytes[2];
          cp = 16'h0000;
          st = u8dec_pkg::ST_CHAR;
          used = 0;
          skip = 1'b0;
          starve = 1'b0;
          if (!b0[7]) begin
            cp = {8'h00, b0};
            used = 1;
          end else if (win_fill < 2 ||
                       (win_fill < 3 && !(b0[7:5] == 3'b110 && b1[7:6] == 2'b10))) begin
            // incomplete head: only decided at the end of the buffer
            if (!fin) starve = 1'b1;
            else if (model_mode == u8dec_pkg::MODE_REPLACE) begin
              cp = u8dec_pkg::REPL_CP;
              used = 1;
            end else st = u8dec_pkg::ST_INVALID;
          end else if (b0[7:5] == 3'b110 && b1[7:6] == 2'b10) begin
            cp = {5'b0, b0[4:0], b1[5:0]};
            if (cp < u8dec_pkg::MIN_CP2) st = u8dec_pkg::ST_OVERLONG;
            else used = 2;
          end else if (b0[7:4] == 4'b1110 && b1[7:6] == 2'b10 && b2[7:6] == 2'b10) begin
            cp = {b0[3:0], b1[5:0], b2[5:0]};
            if (cp < u8dec_pkg::MIN_CP3) st = u8dec_pkg::ST_OVERLONG;
            else used = 3;
          end else if (model_mode == u8dec_pkg::MODE_SKIP) begin
            skip = 1'b1;
          end else if (model_mode == u8dec_pkg::MODE_REPLACE) begin
            cp = u8dec_pkg::REPL_CP;
            used = 1;
          end else begin
            st = u8dec_pkg::ST_INVALID;
          end
          if (starve) begin
            busy = 1'b0;
          end else if (skip) begin
            shift_window(1);
          end else if (st != u8dec_pkg::ST_CHAR) begin
            expect_word(16'h0000, st, 1'b1);
            halted = 1'b1;
          end else begin
            shift_window(used);
            chars_out = count_add(chars_out, 1);
            expect_word(cp, u8dec_pkg::ST_CHAR, 1'b0);
          end
        end
      end
    end
    if (fin) begin
      if (!halted) expect_word(16'h0000, u8dec_pkg::ST_DONE, 1'b1);
      clear_buffer();
    end
  endtask

  // byte driver: predicts on each accepted word, then offers the next one
  always @(posedge clk) begin : drive
    utf8_item_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (utf8_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          item = utf8_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= item.b;
          s_axis_tlast  <= item.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin : watch
    decoded_t got;
    decoded_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cp       = m_axis_tdata[15:0];
        got.st       = u8dec_pkg::status_t'(m_axis_tuser);
        got.chars    = m_axis_tdata[31:16];
        got.consumed = m_axis_tdata[47:32];
        got.last     = m_axis_tlast;
        if (decoded_q.size() == 0) begin
          report_mismatch("word with nothing expected", 32'(m_axis_tdata[15:0]), 32'd0);
        end else begin
          want = decoded_q.pop_front();
          if (got.cp != want.cp)
            report_mismatch("ucs2_char", 32'(got.cp), 32'(want.cp));
          if (got.st != want.st)
            report_mismatch("status", 32'(got.st), 32'(want.st));
          if (got.chars != want.chars)
            report_mismatch("decoded_count", 32'(got.chars), 32'(want.chars));
          if (got.consumed != want.consumed)
            report_mismatch("consumed_bytes", 32'(got.consumed), 32'(want.consumed));
          if (got.last != want.last)
            report_mismatch("last_of_run", 32'(got.last), 32'(want.last));
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_utf8_to_ucs2_stream_decoder: done, errors");
    $finish;
  end

  task automatic settle();
    int waited;
    waited = 0;
    while ((utf8_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) &&
           waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) begin
      report_mismatch("words never delivered", 32'(decoded_q.size()), 32'd0);
      decoded_q.delete();
    end
  endtask

  task automatic write_mode(input u8dec_pkg::mode_t m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_mode = m;
  endtask

  task automatic begin_phase(input u8dec_pkg::mode_t m, input int tx_pct, input int rx_pct);
    settle();
    write_mode(m);
    tx_idle_pct  <= tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  // n bytes from the low end of seq, first byte highest, last one flagged
  task automatic put_seq(input logic [63:0] seq, input int n);
    for (int i = 0; i < n; i++)
      utf8_q.push_back(utf8_item_t'{seq[8*(n-1-i) +: 8], i == n - 1});
    queued_items += n;
  endtask

  // one buffer of random characters, sometimes mixed with malformed bytes
  task automatic put_random_buffer();
    logic [7:0]  seq[$];
    logic [15:0] cp;
    int          noise_pct;
    int          parts;
    noise_pct = ($urandom_range(99) < 70) ? 0 : 30;
    parts = $urandom_range(1, 8);
    for (int p = 0; p < parts; p++) begin
      if ($urandom_range(99) >= noise_pct) begin
        case ($urandom_range(2))
          0: seq.push_back(8'($urandom_range(8'h7F)));
          1: begin
            cp = 16'($urandom_range(16'h0080, 16'h07FF));
            seq.push_back({3'b110, cp[10:6]});
            seq.push_back({2'b10, cp[5:0]});
          end
          default: begin
            cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            seq.push_back({4'b1110, cp[15:12]});
            seq.push_back({2'b10, cp[11:6]});
            seq.push_back({2'b10, cp[5:0]});
          end
        endcase
      end else begin
        case ($urandom_range(4))
          0: seq.push_back(8'($urandom));
          // stray continuation
          1: seq.push_back({2'b10, 6'($urandom)});
          // lead without all its continuations
          2: begin
            if ($urandom_range(1)) begin
              seq.push_back({3'b110, 5'($urandom)});
            end else begin
              seq.push_back({4'b1110, 4'($urandom)});
              seq.push_back({2'b10, 6'($urandom)});
            end
          end
          // overlong two- or three-byte form
          3: begin
            if ($urandom_range(1)) begin
              seq.push_back({7'b1100000, 1'($urandom)});
            end else begin
              seq.push_back(8'hE0);
              seq.push_back({3'b100, 5'($urandom)});
            end
            seq.push_back({2'b10, 6'($urandom)});
          end
          default: seq.push_back({4'b1111, 4'($urandom)});
        endcase
      end
    end
    for (int i = 0; i < seq.size(); i++)
      utf8_q.push_back(utf8_item_t'{seq[i], i == seq.size() - 1});
    queued_items += seq.size();
  endtask

  // stimulus sequence
  initial begin
    int target;
    int start;
    int tx_pct;
    int rx_pct;
    u8dec_pkg::mode_t m;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed buffers, strict mode
    begin_phase(u8dec_pkg::MODE_STRICT, 0, 0);
    put_seq(64'h7F_C2_80_EF_BF_BF, 6);  // top ascii, lowest two-byte, highest three-byte
    put_seq(64'hC0_80, 2);              // overlong two-byte form
    put_seq(64'hFF_41_42_00, 4);        // bad lead stops, rest of buffer ignored
    put_seq(64'h41_E2, 2);              // truncated tail
    // skip mode: stray continuation dropped, truncated tail still an error
    begin_phase(u8dec_pkg::MODE_SKIP, 0, 0);
    put_seq(64'h80_00_42_C3, 4);
    // replace mode: overlong three-byte, then bad lead replaced and re-examined
    begin_phase(u8dec_pkg::MODE_REPLACE, 0, 0);
    put_seq(64'hE0_9F_BF, 3);
    put_seq(64'hC3_41, 2);
    // conflicting mode
    begin_phase(u8dec_pkg::MODE_CONFLICT, 0, 0);
    put_seq(64'h41_42, 2);

    // random phases over every mode and idling pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      m = u8dec_pkg::mode_t'(ph % 4);
      case ((ph + ph / 4) % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 47; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 47; end
        default: begin tx_pct = 27; rx_pct = 27; end
      endcase
      begin_phase(m, tx_pct, rx_pct);
      target = (m == u8dec_pkg::MODE_CONFLICT) ? 12 : (ph == PRESSURE_PHASE) ? 60 : 26;
      if (ph == PRESSURE_PHASE) hold_req = 1'b1;
      start = queued_items;
      while (queued_items - start < target) put_random_buffer();
    end

    settle();
    if (err_count == 0) begin
      $display("tb_utf8_to_ucs2_stream_decoder: done, clean");
    end else begin
      $display("tb_utf8_to_ucs2_stream_decoder: done, errors");
    end
    $finish;
  end

endmodule
